>>> design/wpc_pkg.sv
// shared constants, state types and result struct of the windowed correlation block
`timescale 1ns / 1ps
package wpc_pkg;

	localparam int MAX_HALF_WINDOW = 32;
	localparam int RING_DEPTH      = 64;
	localparam int SAMPLE_W        = 24;
	localparam int PAIR_W          = 2 * SAMPLE_W;
	localparam int POS_W           = 16;
	localparam int CORR_W          = 16;
	localparam int HW_W            = 6;
	localparam logic [HW_W-1:0] HW_RESET = 6'd4;
	// quotient carries 2^30 scale plus one bit for exactly 1.0
	localparam int QUOT_W          = 31;
	localparam int ROOT_W          = 16;
	localparam logic [CORR_W-1:0] CORR_ONE = 16'd32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ACCUM,
		ST_KICK,
		ST_WAIT,
		ST_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		CR_IDLE,
		CR_DIFF,
		CR_MUL,
		CR_DINIT,
		CR_DIV,
		CR_SQRT,
		CR_DONE
	} corr_state_t;

	typedef struct packed {
		logic              done;
		logic [CORR_W-1:0] correlation;
		logic              degenerate;
	} corr_res_t;

endpackage

>>> design/wpc_in_if.sv
// input channel carrying one sample pair per transaction
`timescale 1ns / 1ps
interface wpc_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [wpc_pkg::SAMPLE_W-1:0]  sample_a;
	logic signed [wpc_pkg::SAMPLE_W-1:0]  sample_b;
	logic                                 final_sample;

	modport source (output valid, output sample_a, output sample_b, output final_sample,
		input ready);
	modport sink (input valid, input sample_a, input sample_b, input final_sample,
		output ready);
endinterface

>>> design/wpc_out_if.sv
// output channel carrying one correlation result per transaction
`timescale 1ns / 1ps
interface wpc_out_if;
	logic                         valid;
	logic                         ready;
	logic [wpc_pkg::POS_W-1:0]    position;
	logic [wpc_pkg::CORR_W-1:0]   correlation;
	logic                         degenerate;
	logic                         run_end;

	modport source (output valid, output position, output correlation, output degenerate,
		output run_end, input ready);
	modport sink (input valid, input position, input correlation, input degenerate,
		input run_end, output ready);
endinterface

>>> design/windowed_pearson_correlation_top.sv
// top level: pair chain, window sequencer, correlation unit and output register
`timescale 1ns / 1ps
// Windowed absolute Pearson correlation over a stream of (a, b) sample pairs.
// in_ch takes one pair per transaction; final_sample marks the last pair of a run.
// out_ch gives one result per transaction: position, |r| with 32768 = 1.0,
// a degenerate flag and run_end on the last result caused by an input.
// cfg_we / cfg_wdata write the half window w; write only while the block is idle.
// Pairs live in a chain of RING_DEPTH cells; each result rotates the whole chain
// once to sum the window moments, then the correlation unit runs the serial
// products, the division and the root. An input that is not yet due yields no
// result. The final pair of a run yields up to w results, one after another.
// The block takes one input at a time: in_ch.ready is high only while no result
// is being computed.
// A result waits in the output register while out_ch stalls; the next result is
// computed meanwhile and held until the register frees.
// Reset (arst_n low) clears the sample count, the run state and the output
// valid, and sets w to 4; the pair chain keeps whatever it held.
module windowed_pearson_correlation_top #(
	parameter int MAX_HALF_WINDOW = wpc_pkg::MAX_HALF_WINDOW,
	parameter int RING_DEPTH      = wpc_pkg::RING_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [wpc_pkg::HW_W-1:0] cfg_wdata,
	wpc_in_if.sink                   in_ch,
	wpc_out_if.source                out_ch
);

	localparam int MW   = $clog2(RING_DEPTH + 1);
	localparam int SW   = wpc_pkg::SAMPLE_W + MW;
	localparam int SQW  = 2 * wpc_pkg::SAMPLE_W - 1 + MW;
	localparam int PW   = 2 * wpc_pkg::SAMPLE_W + MW;
	localparam int WCAP = (MAX_HALF_WINDOW < RING_DEPTH / 2) ? MAX_HALF_WINDOW
		: RING_DEPTH / 2;
	localparam int NW   = wpc_pkg::POS_W + 2;
	localparam int SAW  = wpc_pkg::SAMPLE_W;

	wpc_pkg::top_state_t state_q, state_d;

	logic [wpc_pkg::HW_W-1:0]  hw_q, weff;
	logic [wpc_pkg::POS_W-1:0] count_q, count_inc;
	logic                      long_q;
	logic                      in_acc;

	logic [NW-1:0]             n_new, w_new, pos_new;
	logic                      due;

	logic [NW-1:0]             n_q, pos_q, last_q;
	logic [wpc_pkg::HW_W-1:0]  w_q;
	logic                      fin_q;
	logic [MW-1:0]             m_q;
	logic [NW:0]               m_full, m_clip;

	logic [wpc_pkg::PAIR_W-1:0] cell_in  [RING_DEPTH];
	logic [wpc_pkg::PAIR_W-1:0] cell_out [RING_DEPTH];
	logic                       shift_en, rotate, take;
	logic [MW-1:0]              cnt_q;

	logic signed [SAW-1:0]      a_s1, b_s1;
	logic [SQW-1:0]             aa_s1, bb_s1;
	logic signed [2*SAW-1:0]    ab_s1;
	logic                       valid_s1;
	logic signed [2*SAW-1:0]    aa_full, bb_full, ab_full;
	logic signed [SAW-1:0]      tail_a, tail_b;

	logic signed [SW-1:0]       sa_q, sb_q;
	logic [SQW-1:0]             saa_q, sbb_q;
	logic signed [PW-1:0]       sab_q;

	wpc_pkg::corr_res_t         corr_res;
	logic                       corr_start, out_load;

	logic                       out_valid_q;
	logic [wpc_pkg::POS_W-1:0]  out_pos_q;
	logic [wpc_pkg::CORR_W-1:0] out_corr_q;
	logic                       out_degen_q;
	logic                       out_end_q;

	// effective half window: at least 1, at most the cap
	always_comb begin
		if (hw_q == '0) begin
			weff = wpc_pkg::HW_W'(1);
		end else if (hw_q > wpc_pkg::HW_W'(WCAP)) begin
			weff = wpc_pkg::HW_W'(WCAP);
		end else begin
			weff = hw_q;
		end
	end

	// run bookkeeping for the incoming pair
	always_comb begin
		in_acc    = in_ch.valid && in_ch.ready;
		count_inc = count_q + wpc_pkg::POS_W'(1);
		n_new     = NW'({long_q, count_q}) + NW'(1);
		w_new     = NW'(weff);
		due       = in_ch.final_sample || (n_new >= w_new);
		pos_new   = (n_new > w_new) ? (n_new - w_new) : '0;
	end

	// window length for the current position
	always_comb begin
		m_full = fin_q ? ((NW+1)'(n_q) - (NW+1)'(pos_q) + (NW+1)'(w_q))
			: (NW+1)'({w_q, 1'b0});
		m_clip = (m_full > (NW+1)'(n_q)) ? (NW+1)'(n_q) : m_full;
	end

	// sequencer next state and strobes
	always_comb begin
		state_d    = state_q;
		corr_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			wpc_pkg::ST_IDLE: begin
				if (in_acc && due) state_d = wpc_pkg::ST_SETUP;
			end
			wpc_pkg::ST_SETUP: state_d = wpc_pkg::ST_ACCUM;
			wpc_pkg::ST_ACCUM: begin
				if (cnt_q == MW'(RING_DEPTH)) state_d = wpc_pkg::ST_KICK;
			end
			wpc_pkg::ST_KICK: begin
				corr_start = 1'b1;
				state_d    = wpc_pkg::ST_WAIT;
			end
			wpc_pkg::ST_WAIT: begin
				if (corr_res.done) state_d = wpc_pkg::ST_OUT;
			end
			wpc_pkg::ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = (pos_q == last_q) ? wpc_pkg::ST_IDLE : wpc_pkg::ST_SETUP;
				end
			end
			default: state_d = wpc_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wpc_pkg::ST_IDLE;
			hw_q        <= wpc_pkg::HW_RESET;
			count_q     <= '0;
			long_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) hw_q <= cfg_wdata;
			if (in_acc) begin
				if (in_ch.final_sample) begin
					count_q <= '0;
					long_q  <= 1'b0;
				end else begin
					count_q <= count_inc;
					if (count_inc == '0) long_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == wpc_pkg::ST_ACCUM) begin
				cnt_q <= cnt_q + MW'(1);
			end else begin
				cnt_q <= '0;
			end
			valid_s1 <= rotate && take;
		end
	end

	// job registers: a final pair flushes up to w positions, any other due pair gives one
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q    <= n_new;
			w_q    <= weff;
			fin_q  <= in_ch.final_sample;
			pos_q  <= in_ch.final_sample ? pos_new : (n_new - w_new);
			last_q <= in_ch.final_sample ? (n_new - NW'(1)) : (n_new - w_new);
		end else if (out_load) begin
			pos_q <= pos_q + NW'(1);
		end
		if (state_q == wpc_pkg::ST_SETUP) begin
			m_q <= MW'(m_clip);
		end
	end

	// pair chain: shift in on a transaction, rotate once around per result
	assign rotate   = (state_q == wpc_pkg::ST_ACCUM) && (cnt_q != MW'(RING_DEPTH));
	assign shift_en = in_acc || rotate;

	for (genvar j = 0; j < RING_DEPTH; j++) begin : g_chain
		if (j == 0) begin : g_head
			assign cell_in[j] = in_acc ? {in_ch.sample_b, in_ch.sample_a}
				: cell_out[RING_DEPTH-1];
		end else begin : g_link
			assign cell_in[j] = cell_out[j-1];
		end
		wpc_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.pair_in  (cell_in[j]),
			.pair_out (cell_out[j])
		);
	end

	// the tail shows the oldest pair first; the newest m pairs arrive last
	always_comb begin
		take    = ((MW+1)'(cnt_q) + (MW+1)'(m_q)) >= (MW+1)'(RING_DEPTH);
		tail_a  = signed'(cell_out[RING_DEPTH-1][SAW-1:0]);
		tail_b  = signed'(cell_out[RING_DEPTH-1][2*SAW-1:SAW]);
		aa_full = tail_a * tail_a;
		bb_full = tail_b * tail_b;
		ab_full = tail_a * tail_b;
	end

	// product stage
	always_ff @(posedge clk) begin
		a_s1  <= tail_a;
		b_s1  <= tail_b;
		aa_s1 <= SQW'(aa_full[2*SAW-2:0]);
		bb_s1 <= SQW'(bb_full[2*SAW-2:0]);
		ab_s1 <= ab_full;
	end

	// moment accumulators
	always_ff @(posedge clk) begin
		if (state_q == wpc_pkg::ST_SETUP) begin
			sa_q  <= '0;
			sb_q  <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
		end else if (valid_s1) begin
			sa_q  <= sa_q + SW'(a_s1);
			sb_q  <= sb_q + SW'(b_s1);
			saa_q <= saa_q + aa_s1;
			sbb_q <= sbb_q + bb_s1;
			sab_q <= sab_q + PW'(ab_s1);
		end
	end

	wpc_corr #(
		.RING_DEPTH (RING_DEPTH)
	) u_corr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (corr_start),
		.m      (m_q),
		.sa     (sa_q),
		.sb     (sb_q),
		.saa    (saa_q),
		.sbb    (sbb_q),
		.sab    (sab_q),
		.res    (corr_res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q   <= pos_q[wpc_pkg::POS_W-1:0];
			out_corr_q  <= corr_res.correlation;
			out_degen_q <= corr_res.degenerate;
			out_end_q   <= (pos_q == last_q);
		end
	end

	assign in_ch.ready        = (state_q == wpc_pkg::ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.position    = out_pos_q;
	assign out_ch.correlation = out_corr_q;
	assign out_ch.degenerate  = out_degen_q;
	assign out_ch.run_end     = out_end_q;

	// correlation unit finishes only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		corr_res.done |-> state_q == wpc_pkg::ST_WAIT)
		else $error("correlation done outside wait");

	// coefficient never exceeds 1.0
	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_corr_q <= wpc_pkg::CORR_ONE)
		else $error("correlation above one");

	// degenerate windows report zero
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_degen_q) |-> out_corr_q == '0)
		else $error("degenerate result not zero");

	// an accepted pair either starts a window or leaves the block idle
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == wpc_pkg::ST_SETUP || state_q == wpc_pkg::ST_IDLE))
		else $error("bad state after input transaction");

endmodule

>>> design/wpc_cell.sv
// one cell of the pair chain: holds a pair and takes its neighbor's on a shift
`timescale 1ns / 1ps
module wpc_cell (
	input  logic                        clk,
	input  logic                        shift_en,
	input  logic [wpc_pkg::PAIR_W-1:0]  pair_in,
	output logic [wpc_pkg::PAIR_W-1:0]  pair_out
);

	logic [wpc_pkg::PAIR_W-1:0] pair_q;

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (shift_en) begin
			pair_q <= pair_in;
		end
	end

	assign pair_out = pair_q;

endmodule

>>> design/wpc_corr.sv
// correlation unit: moments to variances, serial products, long division, integer root
`timescale 1ns / 1ps
module wpc_corr #(
	parameter int RING_DEPTH = wpc_pkg::RING_DEPTH
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   start,
	input  logic [$clog2(RING_DEPTH+1)-1:0]                        m,
	input  logic signed [wpc_pkg::SAMPLE_W+$clog2(RING_DEPTH+1)-1:0]   sa,
	input  logic signed [wpc_pkg::SAMPLE_W+$clog2(RING_DEPTH+1)-1:0]   sb,
	input  logic [2*wpc_pkg::SAMPLE_W-1+$clog2(RING_DEPTH+1)-1:0]      saa,
	input  logic [2*wpc_pkg::SAMPLE_W-1+$clog2(RING_DEPTH+1)-1:0]      sbb,
	input  logic signed [2*wpc_pkg::SAMPLE_W+$clog2(RING_DEPTH+1)-1:0] sab,
	output wpc_pkg::corr_res_t                                     res
);

	localparam int MW  = $clog2(RING_DEPTH + 1);
	localparam int SW  = wpc_pkg::SAMPLE_W + MW;
	localparam int SQW = 2 * wpc_pkg::SAMPLE_W - 1 + MW;
	localparam int PW  = 2 * wpc_pkg::SAMPLE_W + MW;
	localparam int VW  = 2 * MW + 2 * wpc_pkg::SAMPLE_W + 2;
	localparam int KW  = $clog2(VW + 1);
	localparam int QW  = wpc_pkg::QUOT_W;
	localparam int RW  = wpc_pkg::ROOT_W;

	wpc_pkg::corr_state_t state_q, state_d;

	logic [MW-1:0]                 m_q;
	logic [MW+SQW-1:0]             maa_q, mbb_q;
	logic signed [MW+PW:0]         mab_q;
	logic signed [2*SW-1:0]        sa2_q, sb2_q, sab2_q;

	logic signed [VW-1:0]          va_w, vb_w, c_w;
	logic [VW-1:0]                 cabs_w;
	logic                          degen_w;

	logic [2*VW-1:0]               mc_p_q, mc_c_q, acc_p_q, acc_c_q;
	logic [VW-1:0]                 mp_p_q, mp_c_q;
	logic [KW-1:0]                 cnt_q;

	logic [2*VW:0]                 rem_q, diff_w;
	logic                          ge_w;
	logic [QW-1:0]                 quo_q;

	logic [RW-1:0]                 root_q, bitm_q, trial_w;
	logic [2*RW-1:0]               sq_w;

	logic                          degen_q;

	// variances and covariance from the registered moment products
	always_comb begin
		va_w    = VW'(signed'({1'b0, maa_q})) - VW'(sa2_q);
		vb_w    = VW'(signed'({1'b0, mbb_q})) - VW'(sb2_q);
		c_w     = VW'(mab_q) - VW'(sab2_q);
		cabs_w  = c_w[VW-1] ? VW'(-c_w) : VW'(c_w);
		degen_w = (m_q <= MW'(1)) || (va_w == '0) || (vb_w == '0);
	end

	// one restoring division step and one root trial
	always_comb begin
		ge_w    = rem_q >= {1'b0, acc_p_q};
		diff_w  = ge_w ? (rem_q - {1'b0, acc_p_q}) : rem_q;
		trial_w = root_q | bitm_q;
		sq_w    = trial_w * trial_w;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wpc_pkg::CR_IDLE:  if (start) state_d = wpc_pkg::CR_DIFF;
			wpc_pkg::CR_DIFF:  state_d = degen_w ? wpc_pkg::CR_DONE : wpc_pkg::CR_MUL;
			wpc_pkg::CR_MUL:   if (cnt_q == KW'(VW - 1)) state_d = wpc_pkg::CR_DINIT;
			wpc_pkg::CR_DINIT: state_d = wpc_pkg::CR_DIV;
			wpc_pkg::CR_DIV:   if (cnt_q == KW'(QW - 1)) state_d = wpc_pkg::CR_SQRT;
			wpc_pkg::CR_SQRT:  if (bitm_q[0]) state_d = wpc_pkg::CR_DONE;
			wpc_pkg::CR_DONE:  state_d = wpc_pkg::CR_IDLE;
			default:           state_d = wpc_pkg::CR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpc_pkg::CR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			wpc_pkg::CR_IDLE: begin
				m_q    <= m;
				maa_q  <= m * saa;
				mbb_q  <= m * sbb;
				mab_q  <= signed'({1'b0, m}) * sab;
				sa2_q  <= sa * sa;
				sb2_q  <= sb * sb;
				sab2_q <= sa * sb;
			end
			wpc_pkg::CR_DIFF: begin
				mc_p_q  <= (2*VW)'(va_w);
				mp_p_q  <= vb_w;
				mc_c_q  <= (2*VW)'(cabs_w);
				mp_c_q  <= cabs_w;
				acc_p_q <= '0;
				acc_c_q <= '0;
				cnt_q   <= '0;
				degen_q <= degen_w;
			end
			wpc_pkg::CR_MUL: begin
				if (mp_p_q[0]) acc_p_q <= acc_p_q + mc_p_q;
				if (mp_c_q[0]) acc_c_q <= acc_c_q + mc_c_q;
				mc_p_q <= {mc_p_q[2*VW-2:0], 1'b0};
				mc_c_q <= {mc_c_q[2*VW-2:0], 1'b0};
				mp_p_q <= {1'b0, mp_p_q[VW-1:1]};
				mp_c_q <= {1'b0, mp_c_q[VW-1:1]};
				cnt_q  <= cnt_q + KW'(1);
			end
			wpc_pkg::CR_DINIT: begin
				rem_q <= {1'b0, acc_c_q};
				quo_q <= '0;
				cnt_q <= '0;
			end
			wpc_pkg::CR_DIV: begin
				rem_q  <= {diff_w[2*VW-1:0], 1'b0};
				quo_q  <= {quo_q[QW-2:0], ge_w};
				cnt_q  <= cnt_q + KW'(1);
				root_q <= '0;
				bitm_q <= {1'b1, {(RW-1){1'b0}}};
			end
			wpc_pkg::CR_SQRT: begin
				if (sq_w <= (2*RW)'(quo_q)) root_q <= trial_w;
				bitm_q <= {1'b0, bitm_q[RW-1:1]};
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	// root_q is final when done is shown; degenerate windows read as zero
	assign res.done        = (state_q == wpc_pkg::CR_DONE);
	assign res.correlation = degen_q ? '0 : wpc_pkg::CORR_W'(root_q);
	assign res.degenerate  = degen_q;

endmodule

>>> test/tb_top.sv
// self-checking testbench for the windowed pearson correlation block
`timescale 1ns / 1ps
module tb_top;
	import wpc_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [CORR_W-1:0] correlation;
		logic              degenerate;
		logic              run_end;
	} corr_result_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a;
		logic signed [SAMPLE_W-1:0] b;
		logic                       last;
		logic                       typed;
		corr_result_t               result;
	} stim_row_t;

	localparam int DIR_ROWS = 22;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7fffff;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;
	localparam corr_result_t LONE_RESULT = '{16'd0, 16'd0, 1'b1, 1'b1};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [HW_W-1:0] cfg_wdata;

	wpc_in_if in_ch();
	wpc_out_if out_ch();

	windowed_pearson_correlation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor state
	logic [PAIR_W-1:0] pair_copy [RING_DEPTH];
	int unsigned slot_next;
	int unsigned seen_count;
	bit wrapped_run;
	logic [HW_W-1:0] window_reg;
	corr_result_t pending_results [$];
	int fail_count;
	int run_left;
	int data_mode;

	// directed table, typed results only where obvious
	stim_row_t dir_tab [DIR_ROWS] = '{
		'{S_MAX, S_MAX, 1'b1, 1'b1, LONE_RESULT},
		'{S_MIN, S_MIN, 1'b1, 1'b1, LONE_RESULT},
		'{24'sd0, 24'sd0, 1'b1, 1'b1, LONE_RESULT},
		'{S_MIN, S_MAX, 1'b0, 1'b0, LONE_RESULT},
		'{S_MAX, S_MIN, 1'b1, 1'b0, LONE_RESULT},
		'{24'sd100, 24'sd200, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd200, 24'sd400, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd300, 24'sd600, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd400, 24'sd800, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd500, 24'sd1000, 1'b1, 1'b0, LONE_RESULT},
		'{24'sd5, 24'sd1, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd5, 24'sd7, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd5, -24'sd3, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd5, 24'sd9, 1'b1, 1'b0, LONE_RESULT},
		'{24'sd1, 24'sd3, 1'b0, 1'b0, LONE_RESULT},
		'{-24'sd7, 24'sd2, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd4, -24'sd9, 1'b0, 1'b0, LONE_RESULT},
		'{S_MAX, 24'sd11, 1'b0, 1'b0, LONE_RESULT},
		'{S_MIN, -24'sd5, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd0, S_MAX, 1'b0, 1'b0, LONE_RESULT},
		'{24'sd33, S_MIN, 1'b0, 1'b0, LONE_RESULT},
		'{-24'sd1, 24'sd6, 1'b1, 1'b0, LONE_RESULT}
	};

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap length: mostly none or short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	function automatic int active_window();
		int w;
		w = window_reg;
		if (w < 1) w = 1;
		if (w > MAX_HALF_WINDOW) w = MAX_HALF_WINDOW;
		if (2 * w > RING_DEPTH) w = RING_DEPTH / 2;
		return w;
	endfunction

	// |r| over the newest m pairs, as floor(32768 * |r|)
	function automatic corr_result_t window_corr(int newest, int m, int pos);
		corr_result_t res;
		longint sa, sb, saa, sbb, sab, av, bv, c;
		logic [63:0] va, vb, cabs;
		logic [191:0] prod, rhs, lhs;
		int lo, hi, mid;
		sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
		for (int d = 0; d < m; d++) begin
			av = $signed(pair_copy[(newest + RING_DEPTH - d) % RING_DEPTH][23:0]);
			bv = $signed(pair_copy[(newest + RING_DEPTH - d) % RING_DEPTH][47:24]);
			sa += av; sb += bv; saa += av * av; sbb += bv * bv; sab += av * bv;
		end
		va = m * saa - sa * sa;
		vb = m * sbb - sb * sb;
		c = m * sab - sa * sb;
		res.position = pos[POS_W-1:0];
		res.run_end = 1'b0;
		if (m <= 1 || va == 0 || vb == 0) begin
			res.correlation = '0;
			res.degenerate = 1'b1;
			return res;
		end
		cabs = (c < 0) ? -c : c;
		prod = {128'd0, va} * {128'd0, vb};
		rhs = ({128'd0, cabs} * {128'd0, cabs}) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = prod * (mid * mid);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		res.correlation = lo[CORR_W-1:0];
		res.degenerate = 1'b0;
		return res;
	endfunction

	// advance the predictor by one accepted pair and queue its results
	task automatic predict_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b, logic last);
		int w, newest, k, n, first, m, made;
		w = active_window();
		newest = slot_next % RING_DEPTH;
		pair_copy[newest] = {b, a};
		slot_next = (newest + 1) % RING_DEPTH;
		k = seen_count + (wrapped_run ? 65536 : 0);
		n = k + 1;
		seen_count = (seen_count + 1) & 16'hffff;
		if (seen_count == 0) wrapped_run = 1'b1;
		made = 0;
		if (last) begin
			first = (n - w < 0) ? 0 : n - w;
			for (int i = first; i < n; i++) begin
				m = n - i + w;
				if (m > n) m = n;
				pending_results.insert(pending_results.size(), window_corr(newest, m, i));
				made++;
			end
			seen_count = 0;
			wrapped_run = 1'b0;
		end else if (n - w >= 0) begin
			m = (2 * w > n) ? n : 2 * w;
			pending_results.insert(pending_results.size(), window_corr(newest, m, n - w));
			made++;
		end
		if (made > 0) pending_results[pending_results.size() - 1].run_end = 1'b1;
	endtask

	// one input transaction, driven from the falling edge
	task automatic send_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b, logic last);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.sample_a = a;
		in_ch.sample_b = b;
		in_ch.final_sample = last;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		predict_pair(a, b, last);
		@(negedge clk);
	endtask

	// register write once everything due has come out
	task automatic write_window(logic [HW_W-1:0] value);
		in_ch.valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(posedge clk);
		window_reg = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// random pair content in the style of the current run
	task automatic random_pair(output logic [SAMPLE_W-1:0] a, output logic [SAMPLE_W-1:0] b);
		int base;
		case (data_mode)
			0: begin
				a = SAMPLE_W'($urandom);
				b = SAMPLE_W'($urandom);
			end
			1: begin
				base = int'($urandom_range(0, 8000)) - 4000;
				a = SAMPLE_W'(base);
				b = SAMPLE_W'(base * 3 + int'($urandom_range(0, 40)) - 20);
			end
			2: begin
				a = 24'sd77;
				b = SAMPLE_W'($urandom_range(0, 1000));
			end
			default: begin
				a = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
				b = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
			end
		endcase
	endtask

	task automatic random_phase(int count);
		logic [SAMPLE_W-1:0] a, b;
		for (int j = 0; j < count; j++) begin
			if (run_left <= 0) begin
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 100)
					: $urandom_range(1, 40);
				data_mode = $urandom_range(0, 3);
			end
			random_pair(a, b);
			run_left--;
			send_pair(a, b, run_left == 0);
		end
	endtask

	// output ready with random stalls and stall-free stretches
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if ($urandom_range(0, 3) != 0) begin
				out_ch.ready = 1'b0;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		corr_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result pos %0d corr %0d", $time,
					out_ch.position, out_ch.correlation);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.position !== want.position) begin
					$display("%0t: position expected %0d actual %0d", $time,
						want.position, out_ch.position);
					fail_count++;
				end
				if (out_ch.correlation !== want.correlation) begin
					$display("%0t: correlation expected %0d actual %0d (pos %0d)", $time,
						want.correlation, out_ch.correlation, want.position);
					fail_count++;
				end
				if (out_ch.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %0d actual %0d (pos %0d)", $time,
						want.degenerate, out_ch.degenerate, want.position);
					fail_count++;
				end
				if (out_ch.run_end !== want.run_end) begin
					$display("%0t: run_end expected %0d actual %0d (pos %0d)", $time,
						want.run_end, out_ch.run_end, want.position);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("windowed_pearson_correlation_top regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample_a = '0;
		in_ch.sample_b = '0;
		in_ch.final_sample = 1'b0;
		slot_next = 0;
		seen_count = 0;
		wrapped_run = 1'b0;
		window_reg = HW_RESET;
		fail_count = 0;
		run_left = 0;
		data_mode = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at the reset window
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_pair(dir_tab[r].a, dir_tab[r].b, dir_tab[r].last);
			if (dir_tab[r].typed) pending_results[pending_results.size() - 1] = dir_tab[r].result;
		end

		// random phases over several window settings, extremes included
		write_window(6'd1);
		random_phase(70);
		write_window(6'd32);
		random_phase(70);
		write_window(6'd0);
		random_phase(40);
		write_window(6'd63);
		random_phase(40);
		for (int p = 0; p < 3; p++) begin
			write_window(HW_W'($urandom_range(0, 63)));
			random_phase(80);
		end
		random_pair(in_ch.sample_a, in_ch.sample_b);
		send_pair(in_ch.sample_a, in_ch.sample_b, 1'b1);
		in_ch.valid = 1'b0;

		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("windowed_pearson_correlation_top regression: pass");
		end else begin
			$display("windowed_pearson_correlation_top regression: fail");
		end
		$finish;
	end
endmodule

>>> sim.f
design/wpc_pkg.sv
design/wpc_in_if.sv
design/wpc_out_if.sv
design/wpc_cell.sv
design/wpc_corr.sv
design/windowed_pearson_correlation_top.sv
test/tb_top.sv
